>>> hdl/rtc_pkg.sv
// Package for the RGB565 tone correction block: widths, constants, register indexes.
package rtc_pkg;

  localparam int unsigned RTC_PIX_W  = 16;
  localparam int unsigned RTC_RB_W   = 5;
  localparam int unsigned RTC_G_W    = 6;
  localparam int unsigned RTC_GAIN_W = 7;
  localparam int unsigned RTC_SAT_W  = 8;
  localparam int unsigned RTC_CFG_W  = 8;
  localparam int unsigned RTC_IDX_W  = 2;
  localparam int unsigned RTC_LAT    = 7;

  localparam int unsigned GAIN_MAX = 100;
  localparam int unsigned SAT_MAX  = 200;
  localparam int unsigned UNITY    = 100;

  localparam int unsigned LUMA_R = 77;
  localparam int unsigned LUMA_G = 151;
  localparam int unsigned LUMA_B = 28;

  // reciprocal multipliers, exact over the ranges they see
  localparam int unsigned DIV31_MUL  = 8457;
  localparam int unsigned DIV31_SH   = 18;
  localparam int unsigned DIV63_MUL  = 16645;
  localparam int unsigned DIV63_SH   = 20;
  localparam int unsigned DIV100_MUL = 83887;
  localparam int unsigned DIV100_SH  = 23;
  localparam int unsigned DIV255_MUL = 16449;
  localparam int unsigned DIV255_SH  = 22;

  typedef enum logic [RTC_IDX_W-1:0] {
    REG_GAIN_RED   = 2'd0,
    REG_GAIN_GREEN = 2'd1,
    REG_GAIN_BLUE  = 2'd2,
    REG_SATURATION = 2'd3
  } rtc_reg_e;

endpackage

>>> hdl/rtc_chan.sv
// One colour channel: saturation blend, gain and requantise, five register stages.
module rtc_chan #(
  parameter int unsigned OutW = rtc_pkg::RTC_RB_W
) (
  input  logic                              clk_i,
  input  logic [7:0]                        c_i,
  input  logic [7:0]                        lum_i,
  input  logic [rtc_pkg::RTC_SAT_W-1:0]     sat_i,
  input  logic [rtc_pkg::RTC_GAIN_W-1:0]    gain_i,
  output logic [OutW-1:0]                   q_o
);
  import rtc_pkg::*;

  localparam int unsigned RxW = OutW + 8;
  localparam int unsigned RwW = RxW + 15;

  logic signed [8:0]  diff;
  logic [7:0]         mag;
  logic [15:0]        prod_q;
  logic               neg_q;
  logic [7:0]         lum_q;
  logic [32:0]        qw;
  logic [8:0]         qv;
  logic signed [10:0] bl;
  logic [7:0]         blend_d;
  logic [7:0]         blend_q;
  logic [14:0]        gp_q;
  logic [31:0]        gw;
  logic [7:0]         sc_q;
  logic [RxW-1:0]     rx;
  logic [RwW-1:0]     rw;
  logic [OutW-1:0]    q_q;

  assign diff = $signed({1'b0, c_i}) - $signed({1'b0, lum_i});
  assign mag  = diff[8] ? 8'(-diff) : diff[7:0];

  // |c - lum| * sat, divided by 100 on magnitude so it truncates toward zero
  assign qw = 33'(prod_q) * 33'(DIV100_MUL);
  assign qv = qw[DIV100_SH+8:DIV100_SH];
  assign bl = neg_q ? ($signed({3'b000, lum_q}) - $signed({2'b00, qv}))
                    : ($signed({3'b000, lum_q}) + $signed({2'b00, qv}));

  always_comb begin
    if (bl < 0) begin
      blend_d = 8'd0;
    end else if (bl > 11'sd255) begin
      blend_d = 8'd255;
    end else begin
      blend_d = bl[7:0];
    end
  end

  assign gw = 32'(gp_q) * 32'(DIV100_MUL);
  assign rx = {sc_q, {OutW{1'b0}}} - RxW'(sc_q);
  assign rw = RwW'(rx) * RwW'(DIV255_MUL);

  always_ff @(posedge clk_i) begin
    prod_q  <= 16'(mag) * 16'(sat_i);
    neg_q   <= diff[8];
    lum_q   <= lum_i;
    blend_q <= blend_d;
    gp_q    <= 15'(blend_q) * 15'(gain_i);
    sc_q    <= gw[DIV100_SH+7:DIV100_SH];
    q_q     <= rw[DIV255_SH+OutW-1:DIV255_SH];
  end

  assign q_o = q_q;

endmodule

>>> hdl/rgb565_tone_correction.sv
// Top level of the RGB565 tone correction block: config registers, expand, luma, channels.
//
//  channel   ports                                  handshake
//  pixel in  start_i, busy_o, pixel_in_i            beat when start_i && !busy_o
//  pixel out done_o, pixel_out_o                    one-cycle strobe, no back-pressure
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i       write when cfg_we_i
//
// One beat per cycle; the registered stages are expand, luma, then five
// stages per channel (blend multiply, divide and clamp, gain multiply,
// divide, requantise). busy_o is always low; results cannot be stalled.
// Reset returns all gains and saturation to 100 and clears the valid line.
module rgb565_tone_correction (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [rtc_pkg::RTC_PIX_W-1:0]     pixel_in_i,
  output logic                              done_o,
  output logic [rtc_pkg::RTC_PIX_W-1:0]     pixel_out_o,
  input  logic                              cfg_we_i,
  input  logic [rtc_pkg::RTC_IDX_W-1:0]     cfg_idx_i,
  input  logic [rtc_pkg::RTC_CFG_W-1:0]     cfg_wdata_i
);
  import rtc_pkg::*;

  logic [RTC_GAIN_W-1:0] gain_red_q, gain_green_q, gain_blue_q;
  logic [RTC_SAT_W-1:0]  sat_q;
  logic [RTC_GAIN_W-1:0] gain_wr;
  logic [RTC_SAT_W-1:0]  sat_wr;
  logic                  bypass;

  logic [RTC_LAT-1:0]    valid_q;
  logic [RTC_PIX_W-1:0]  pix_q [RTC_LAT];

  logic [RTC_RB_W-1:0]   r5, b5;
  logic [RTC_G_W-1:0]    g6;
  logic [12:0]           rx, bx;
  logic [13:0]           gx;
  logic [26:0]           rw, bw;
  logic [28:0]           gw;
  logic [7:0]            r1_q, g1_q, b1_q;
  logic [7:0]            r2_q, g2_q, b2_q;
  logic [15:0]           luma;
  logic [7:0]            lum_q;
  logic [RTC_RB_W-1:0]   r_o, b_o;
  logic [RTC_G_W-1:0]    g_o;

  // config
  assign gain_wr = (cfg_wdata_i[RTC_GAIN_W-1:0] > RTC_GAIN_W'(GAIN_MAX)) ?
                   RTC_GAIN_W'(GAIN_MAX) : cfg_wdata_i[RTC_GAIN_W-1:0];
  assign sat_wr  = (cfg_wdata_i[RTC_SAT_W-1:0] > RTC_SAT_W'(SAT_MAX)) ?
                   RTC_SAT_W'(SAT_MAX) : cfg_wdata_i[RTC_SAT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_red_q   <= RTC_GAIN_W'(UNITY);
      gain_green_q <= RTC_GAIN_W'(UNITY);
      gain_blue_q  <= RTC_GAIN_W'(UNITY);
      sat_q        <= RTC_SAT_W'(UNITY);
    end else if (cfg_we_i) begin
      unique case (rtc_reg_e'(cfg_idx_i))
        REG_GAIN_RED:   gain_red_q   <= gain_wr;
        REG_GAIN_GREEN: gain_green_q <= gain_wr;
        REG_GAIN_BLUE:  gain_blue_q  <= gain_wr;
        REG_SATURATION: sat_q        <= sat_wr;
      endcase
    end
  end

  assign bypass = (gain_red_q == RTC_GAIN_W'(UNITY)) && (gain_green_q == RTC_GAIN_W'(UNITY)) &&
                  (gain_blue_q == RTC_GAIN_W'(UNITY)) && (sat_q == RTC_SAT_W'(UNITY));

  // valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[RTC_LAT-2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q[0] <= pixel_in_i;
    for (int i = 1; i < RTC_LAT; i++) begin
      pix_q[i] <= pix_q[i-1];
    end
  end

  // expand to 8 bits: c*255/31, c*255/63
  assign r5 = pixel_in_i[15:11];
  assign g6 = pixel_in_i[10:5];
  assign b5 = pixel_in_i[4:0];
  assign rx = {r5, 8'd0} - 13'(r5);
  assign gx = {g6, 8'd0} - 14'(g6);
  assign bx = {b5, 8'd0} - 13'(b5);
  assign rw = 27'(rx) * 27'(DIV31_MUL);
  assign gw = 29'(gx) * 29'(DIV63_MUL);
  assign bw = 27'(bx) * 27'(DIV31_MUL);

  assign luma = 16'(r1_q) * 16'(LUMA_R) + 16'(g1_q) * 16'(LUMA_G) +
                16'(b1_q) * 16'(LUMA_B);

  always_ff @(posedge clk_i) begin
    r1_q  <= rw[DIV31_SH+7:DIV31_SH];
    g1_q  <= gw[DIV63_SH+7:DIV63_SH];
    b1_q  <= bw[DIV31_SH+7:DIV31_SH];
    r2_q  <= r1_q;
    g2_q  <= g1_q;
    b2_q  <= b1_q;
    lum_q <= luma[15:8];
  end

  rtc_chan #(.OutW(RTC_RB_W)) u_chan_r (
    .clk_i  (clk_i),
    .c_i    (r2_q),
    .lum_i  (lum_q),
    .sat_i  (sat_q),
    .gain_i (gain_red_q),
    .q_o    (r_o)
  );

  rtc_chan #(.OutW(RTC_G_W)) u_chan_g (
    .clk_i  (clk_i),
    .c_i    (g2_q),
    .lum_i  (lum_q),
    .sat_i  (sat_q),
    .gain_i (gain_green_q),
    .q_o    (g_o)
  );

  rtc_chan #(.OutW(RTC_RB_W)) u_chan_b (
    .clk_i  (clk_i),
    .c_i    (b2_q),
    .lum_i  (lum_q),
    .sat_i  (sat_q),
    .gain_i (gain_blue_q),
    .q_o    (b_o)
  );

  assign busy_o      = 1'b0;
  assign done_o      = valid_q[RTC_LAT-1];
  assign pixel_out_o = bypass ? pix_q[RTC_LAT-1] : {r_o, g_o, b_o};

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, RTC_LAT))
    else $error("result beat without a matching input beat");

  a_bypass_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && bypass) |-> (pixel_out_o == $past(pixel_in_i, RTC_LAT)))
    else $error("bypass pixel altered");

  a_zero_red_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (gain_red_q == '0)) |-> (pixel_out_o[15:11] == '0))
    else $error("red not blanked at zero gain");

  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i == REG_SATURATION)) |=> (sat_q <= RTC_SAT_W'(SAT_MAX)))
    else $error("saturation stored above its limit");

endmodule
